// File: src/c2e_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package c2e_pkg;

  // default build of the core
  localparam int FracBits     = 8;
  localparam int CordicStages = 16;
  localparam int MaxSize      = 8192;

  // field and register widths
  localparam int CfgW   = 14;
  localparam int PixW   = 13;
  localparam int FaceW  = 3;
  localparam int CoordW = 21;

  // fixed-point formats
  localparam int QFrac     = 24;          // direction components, Q24
  localparam int NormW     = QFrac + 1;   // normalized pixel 0..1 in Q24
  localparam int DirW      = 28;          // signed direction / cordic magnitude
  localparam int AngFrac   = 30;          // angles, Q30
  localparam int AngW      = 34;          // signed angle, holds up to 1.5 pi
  localparam int ScaleW    = 30;          // signed angle-to-coordinate scale
  localparam int AngProdW  = AngW + ScaleW;
  localparam int TW        = 31;          // unsigned scaled angle plus half

  localparam logic signed [DirW-1:0] OneQ24      = DirW'(1) << QFrac;
  localparam logic signed [AngW-1:0] PiQ30       = 34'sd3373259426;
  localparam logic signed [AngW-1:0] HalfQ30     = 34'sd536870912;
  localparam logic signed [30:0]     InvGainQ30  = 31'sd652032874;
  localparam logic signed [ScaleW-1:0] LonScaleQ30 = 30'sd170832324;
  localparam logic signed [ScaleW-1:0] LatScaleQ30 = 30'sd341772023;

  // register indexes of the configuration port
  typedef enum logic [1:0] {
    CFG_FACE_W = 2'd0,
    CFG_FACE_H = 2'd1,
    CFG_SRC_W  = 2'd2,
    CFG_SRC_H  = 2'd3
  } cfg_idx_e;

  // cube faces
  typedef enum logic [FaceW-1:0] {
    FACE_PX = 3'd0,
    FACE_NX = 3'd1,
    FACE_PY = 3'd2,
    FACE_NY = 3'd3,
    FACE_PZ = 3'd4,
    FACE_NZ = 3'd5
  } face_e;

  // sideband of the longitude pass
  typedef struct packed {
    logic signed [DirW-1:0] y;
    logic signed [AngW-1:0] base;
    logic                   zero;
    logic                   bad;
  } lon_sb_t;

  // sideband of the latitude pass
  typedef struct packed {
    logic signed [AngW-1:0] lon;
    logic                   bad;
  } lat_sb_t;

  // arctangent of 2^-i in Q30
  function automatic logic [31:0] c2e_atan(input int i);
    case (i)
      0:  return 32'h3243F6A8;
      1:  return 32'h1DAC6705;
      2:  return 32'h0FADBAFC;
      3:  return 32'h07F56EA6;
      4:  return 32'h03FEAB76;
      5:  return 32'h01FFD55B;
      6:  return 32'h00FFFAAA;
      7:  return 32'h007FFF55;
      8:  return 32'h003FFFEA;
      9:  return 32'h001FFFFD;
      10: return 32'h000FFFFF;
      11: return 32'h0007FFFF;
      12: return 32'h0003FFFF;
      13: return 32'h0001FFFF;
      14: return 32'h0000FFFF;
      15: return 32'h00007FFF;
      16: return 32'h00003FFF;
      17: return 32'h00001FFF;
      18: return 32'h00000FFF;
      19: return 32'h000007FF;
      20: return 32'h000003FF;
      21: return 32'h000001FF;
      22: return 32'h000000FF;
      23: return 32'h0000007F;
      default: return 32'h0;
    endcase
  endfunction

endpackage

`default_nettype wire

// File: src/c2e_div.sv
`timescale 1ns / 1ps
`default_nettype none

module c2e_div
  import c2e_pkg::*;
#(
  parameter int DivW = 15,
  parameter int SbW  = 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [PixW-1:0]   pix_i,
  input  logic [DivW-1:0]   div_i,
  input  logic [SbW-1:0]    sb_i,
  output logic              valid_o,
  output logic [NormW-1:0]  quo_o,
  output logic [SbW-1:0]    sb_o
);

  localparam int NumW = PixW + 1 + QFrac;
  localparam int RemW = DivW + QFrac;
  localparam int CmpW = (NumW > RemW) ? NumW : RemW;

  logic [NumW-1:0] num;
  logic [CmpW-1:0] num_ext;
  logic [CmpW-1:0] lim_ext;
  logic            sat;

  logic [RemW-1:0]  rem_q [0:QFrac];
  logic [QFrac-1:0] quo_q [0:QFrac];
  logic             sat_q [0:QFrac];
  logic             vld_q [0:QFrac];
  logic [SbW-1:0]   sb_q  [0:QFrac];

  // numerator 2*p in Q24, saturate when the quotient reaches one
  assign num     = {pix_i, 1'b0, {QFrac{1'b0}}};
  assign num_ext = CmpW'(num);
  assign lim_ext = CmpW'({div_i, {QFrac{1'b0}}});
  assign sat     = num_ext >= lim_ext;

  // entry stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= RemW'(num);
      quo_q[0] <= '0;
      sat_q[0] <= sat;
      sb_q[0]  <= sb_i;
    end
  end

  // one quotient bit per stage, msb first
  for (genvar j = 1; j <= QFrac; j++) begin : g_bit
    localparam int K = QFrac - j;
    logic [RemW-1:0] trial;
    logic            ge;

    assign trial = RemW'(div_i) << K;
    assign ge    = rem_q[j-1] >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= ge ? (rem_q[j-1] - trial) : rem_q[j-1];
        quo_q[j] <= quo_q[j-1] | (QFrac'(ge) << K);
        sat_q[j] <= sat_q[j-1];
        sb_q[j]  <= sb_q[j-1];
      end
    end
  end

  assign valid_o = vld_q[QFrac];
  assign quo_o   = sat_q[QFrac] ? {1'b1, {QFrac{1'b0}}} : {1'b0, quo_q[QFrac]};
  assign sb_o    = sb_q[QFrac];

endmodule

`default_nettype wire

// File: src/c2e_cordic.sv
`timescale 1ns / 1ps
`default_nettype none

module c2e_cordic
  import c2e_pkg::*;
#(
  parameter int Stages = CordicStages,
  parameter int SbW    = 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic signed [DirW-1:0] x_i,
  input  logic signed [DirW-1:0] y_i,
  input  logic [SbW-1:0]         sb_i,
  output logic                   valid_o,
  output logic signed [DirW-1:0] x_o,
  output logic signed [AngW-1:0] ang_o,
  output logic [SbW-1:0]         sb_o
);

  logic signed [DirW-1:0] x_q   [0:Stages-1];
  logic signed [DirW-1:0] y_q   [0:Stages-1];
  logic signed [AngW-1:0] a_q   [0:Stages-1];
  logic                   vld_q [0:Stages-1];
  logic [SbW-1:0]         sb_q  [0:Stages-1];

  // one micro-rotation per stage, driving y toward zero
  for (genvar i = 0; i < Stages; i++) begin : g_stage
    logic signed [DirW-1:0] cur_x, cur_y, xs, ys;
    logic signed [AngW-1:0] cur_a, at;
    logic                   cur_v;
    logic [SbW-1:0]         cur_sb;
    logic                   pos;

    if (i == 0) begin : g_first
      assign cur_x  = x_i;
      assign cur_y  = y_i;
      assign cur_a  = '0;
      assign cur_v  = valid_i;
      assign cur_sb = sb_i;
    end else begin : g_next
      assign cur_x  = x_q[i-1];
      assign cur_y  = y_q[i-1];
      assign cur_a  = a_q[i-1];
      assign cur_v  = vld_q[i-1];
      assign cur_sb = sb_q[i-1];
    end

    assign xs  = cur_x >>> i;
    assign ys  = cur_y >>> i;
    assign at  = AngW'(c2e_atan(i));
    assign pos = cur_y > 0;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= cur_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i]  <= pos ? (cur_x + ys) : (cur_x - ys);
        y_q[i]  <= pos ? (cur_y - xs) : (cur_y + xs);
        a_q[i]  <= pos ? (cur_a + at) : (cur_a - at);
        sb_q[i] <= cur_sb;
      end
    end
  end

  assign valid_o = vld_q[Stages-1];
  assign x_o     = x_q[Stages-1];
  assign ang_o   = a_q[Stages-1];
  assign sb_o    = sb_q[Stages-1];

endmodule

`default_nettype wire

// File: src/cubemap_face_to_equirect_coord_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Maps a cube-face pixel to the equirectangular source coordinate to sample.
// Fully pipelined: one word is accepted per clock while the skid entry is
// empty, and results leave in order. The pipe holds 25 stages of the
// bit-per-stage pixel normalizing divider, one direction stage, two CORDIC
// vectoring passes of CORDIC_STAGES stages, one gain-correction multiply and
// three scaling stages. A two-entry output (result register plus skid) lets
// the pipe keep moving in the cycle in which the consumer stalls. Sizes of 0
// read as 1, sizes above MAX_SIZE as MAX_SIZE. Configuration must only be
// written while the pipe is empty.
module cubemap_face_to_equirect_coord_core
  import c2e_pkg::*;
#(
  parameter int FRAC_BITS     = FracBits,
  parameter int CORDIC_STAGES = CordicStages,
  parameter int MAX_SIZE      = MaxSize
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [CfgW-1:0]   cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [FaceW-1:0]  face_i,
  input  logic [PixW-1:0]   pix_x_i,
  input  logic [PixW-1:0]   pix_y_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CoordW-1:0] sample_x_o,
  output logic [CoordW-1:0] sample_y_o,
  output logic              bad_face_o
);

  localparam int SizeW  = $clog2(MAX_SIZE + 1);
  localparam int DivW   = SizeW + 1;
  localparam int CProdW = TW + SizeW;
  localparam int LonSbW = $bits(lon_sb_t);
  localparam int LatSbW = $bits(lat_sb_t);

  function automatic logic [SizeW-1:0] eff_size(input logic [CfgW-1:0] r);
    logic [31:0] rw;
    rw = 32'(r);
    if (rw == 32'd0) return SizeW'(1);
    else if (rw > 32'(MAX_SIZE)) return SizeW'(MAX_SIZE);
    else return SizeW'(rw);
  endfunction

  logic en;

  // configuration registers
  logic [CfgW-1:0] face_w_q, face_h_q, src_w_q, src_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      face_w_q <= CfgW'(512);
      face_h_q <= CfgW'(512);
      src_w_q  <= CfgW'(2048);
      src_h_q  <= CfgW'(1024);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_FACE_W: face_w_q <= cfg_data_i;
        CFG_FACE_H: face_h_q <= cfg_data_i;
        CFG_SRC_W:  src_w_q  <= cfg_data_i;
        CFG_SRC_H:  src_h_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamped sizes and divisors 2*size-1
  logic [SizeW-1:0] fw_eff, fh_eff, sw_eff, sh_eff;
  logic [DivW-1:0]  div_u, div_v;

  assign fw_eff = eff_size(face_w_q);
  assign fh_eff = eff_size(face_h_q);
  assign sw_eff = eff_size(src_w_q);
  assign sh_eff = eff_size(src_h_q);
  assign div_u  = {fw_eff, 1'b0} - DivW'(1);
  assign div_v  = {fh_eff, 1'b0} - DivW'(1);

  // pixel normalizing dividers
  logic             du_vld, dv_vld;
  logic [NormW-1:0] nu, nv;
  logic [FaceW-1:0] du_face, dv_face;

  c2e_div #(.DivW(DivW), .SbW(FaceW)) u_div_u (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .pix_i   (pix_x_i),
    .div_i   (div_u),
    .sb_i    (face_i),
    .valid_o (du_vld),
    .quo_o   (nu),
    .sb_o    (du_face)
  );

  c2e_div #(.DivW(DivW), .SbW(FaceW)) u_div_v (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .pix_i   (pix_y_i),
    .div_i   (div_v),
    .sb_i    (face_i),
    .valid_o (dv_vld),
    .quo_o   (nv),
    .sb_o    (dv_face)
  );

  // face direction, folded into the right half plane
  logic signed [DirW-1:0] u, v, fx, fy, fz;
  logic signed [DirW-1:0] dir_x_d, dir_z_d;
  logic signed [AngW-1:0] base_d;
  logic                   bad_d;

  assign u = $signed({2'b00, nu, 1'b0}) - OneQ24;
  assign v = $signed({2'b00, nv, 1'b0}) - OneQ24;
  assign bad_d = du_face > FACE_NZ;

  always_comb begin
    case (face_e'(du_face))
      FACE_PX: begin fx = OneQ24;  fy = -v;      fz = -u;      end
      FACE_NX: begin fx = -OneQ24; fy = -v;      fz = u;       end
      FACE_PY: begin fx = u;       fy = OneQ24;  fz = v;       end
      FACE_NY: begin fx = u;       fy = -OneQ24; fz = -v;      end
      FACE_PZ: begin fx = u;       fy = -v;      fz = OneQ24;  end
      default: begin fx = -u;      fy = -v;      fz = -OneQ24; end
    endcase
    if (fx < 0) begin
      base_d  = (fz >= 0) ? PiQ30 : -PiQ30;
      dir_x_d = -fx;
      dir_z_d = -fz;
    end else begin
      base_d  = '0;
      dir_x_d = fx;
      dir_z_d = fz;
    end
  end

  logic                   dir_vld_q;
  logic signed [DirW-1:0] dir_x_q, dir_z_q;
  lon_sb_t                dir_sb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_vld_q <= 1'b0;
    end else if (en) begin
      dir_vld_q <= du_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dir_x_q       <= dir_x_d;
      dir_z_q       <= dir_z_d;
      dir_sb_q.y    <= fy;
      dir_sb_q.base <= base_d;
      dir_sb_q.zero <= (fx == 0) && (fz == 0);
      dir_sb_q.bad  <= bad_d;
    end
  end

  // longitude pass: atan2(z, x) and gain-scaled horizontal magnitude
  logic                   c1_vld;
  logic signed [DirW-1:0] c1_x;
  logic signed [AngW-1:0] c1_ang;
  logic [LonSbW-1:0]      c1_sb_raw;
  lon_sb_t                c1_sb;

  c2e_cordic #(.Stages(CORDIC_STAGES), .SbW(LonSbW)) u_cordic_lon (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dir_vld_q),
    .x_i     (dir_x_q),
    .y_i     (dir_z_q),
    .sb_i    (dir_sb_q),
    .valid_o (c1_vld),
    .x_o     (c1_x),
    .ang_o   (c1_ang),
    .sb_o    (c1_sb_raw)
  );

  assign c1_sb = lon_sb_t'(c1_sb_raw);

  // remove cordic gain from the magnitude
  logic signed [DirW+30:0] gain_prod;
  logic signed [DirW-1:0]  mag_d;
  logic signed [AngW-1:0]  lon_d;

  assign gain_prod = c1_x * InvGainQ30;
  assign mag_d     = c1_sb.zero ? '0 : DirW'(gain_prod >>> AngFrac);
  assign lon_d     = c1_sb.zero ? '0 : (c1_sb.base + c1_ang);

  logic                   mag_vld_q;
  logic signed [DirW-1:0] mag_q, mag_y_q;
  lat_sb_t                mag_sb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_vld_q <= 1'b0;
    end else if (en) begin
      mag_vld_q <= c1_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_q        <= mag_d;
      mag_y_q      <= c1_sb.y;
      mag_sb_q.lon <= lon_d;
      mag_sb_q.bad <= c1_sb.bad;
    end
  end

  // latitude pass: atan2(y, horizontal magnitude)
  logic                   c2_vld;
  logic signed [DirW-1:0] c2_x;
  logic signed [AngW-1:0] c2_ang;
  logic [LatSbW-1:0]      c2_sb_raw;
  lat_sb_t                c2_sb;

  c2e_cordic #(.Stages(CORDIC_STAGES), .SbW(LatSbW)) u_cordic_lat (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (mag_vld_q),
    .x_i     (mag_q),
    .y_i     (mag_y_q),
    .sb_i    (mag_sb_q),
    .valid_o (c2_vld),
    .x_o     (c2_x),
    .ang_o   (c2_ang),
    .sb_o    (c2_sb_raw)
  );

  assign c2_sb = lat_sb_t'(c2_sb_raw);

  // scale angles to unit range
  logic                       sc_vld_q, sc_bad_q;
  logic signed [AngProdW-1:0] sc_lon_q, sc_lat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_vld_q <= 1'b0;
    end else if (en) begin
      sc_vld_q <= c2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sc_lon_q <= c2_sb.lon * LonScaleQ30;
      sc_lat_q <= c2_ang * LatScaleQ30;
      sc_bad_q <= c2_sb.bad;
    end
  end

  // add one half, clamp below zero, multiply by source size
  logic signed [AngW-1:0] tx_s, ty_s;
  logic [TW-1:0]          tx, ty;

  assign tx_s = AngW'(sc_lon_q >>> AngFrac) + HalfQ30;
  assign ty_s = AngW'(sc_lat_q >>> AngFrac) + HalfQ30;
  assign tx   = (tx_s < 0) ? '0 : tx_s[TW-1:0];
  assign ty   = (ty_s < 0) ? '0 : ty_s[TW-1:0];

  logic              cp_vld_q, cp_bad_q;
  logic [CProdW-1:0] cp_x_q, cp_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cp_vld_q <= 1'b0;
    end else if (en) begin
      cp_vld_q <= sc_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cp_x_q   <= CProdW'(tx) * CProdW'(sw_eff);
      cp_y_q   <= CProdW'(ty) * CProdW'(sh_eff);
      cp_bad_q <= sc_bad_q;
    end
  end

  // truncate to output fraction and clamp to size-1
  logic [CProdW-1:0] cx, cy, lim_x, lim_y;
  logic [CoordW-1:0] sx_d, sy_d;

  assign cx    = cp_x_q >> (AngFrac - FRAC_BITS);
  assign cy    = cp_y_q >> (AngFrac - FRAC_BITS);
  assign lim_x = CProdW'(sw_eff - SizeW'(1)) << FRAC_BITS;
  assign lim_y = CProdW'(sh_eff - SizeW'(1)) << FRAC_BITS;
  assign sx_d  = cp_bad_q ? '0 : CoordW'((cx > lim_x) ? lim_x : cx);
  assign sy_d  = cp_bad_q ? '0 : CoordW'((cy > lim_y) ? lim_y : cy);

  logic              fin_vld_q, fin_bad_q;
  logic [CoordW-1:0] fin_x_q, fin_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_vld_q <= 1'b0;
    end else if (en) begin
      fin_vld_q <= cp_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fin_x_q   <= sx_d;
      fin_y_q   <= sy_d;
      fin_bad_q <= cp_bad_q;
    end
  end

  // skid entry catches the word the pipe pushes out during a stall
  logic              sk_vld_q, sk_vld_d, sk_load;
  logic              sk_bad_q;
  logic [CoordW-1:0] sk_x_q, sk_y_q;

  assign sk_load = !sk_vld_q && fin_vld_q && !out_ready_i;

  always_comb begin
    sk_vld_d = sk_vld_q;
    if (sk_vld_q && out_ready_i) begin
      sk_vld_d = 1'b0;
    end else if (sk_load) begin
      sk_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sk_vld_q <= 1'b0;
    end else begin
      sk_vld_q <= sk_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sk_load) begin
      sk_x_q   <= fin_x_q;
      sk_y_q   <= fin_y_q;
      sk_bad_q <= fin_bad_q;
    end
  end

  assign en          = !sk_vld_q;
  assign in_ready_o  = en;
  assign out_valid_o = sk_vld_q || fin_vld_q;
  assign sample_x_o  = sk_vld_q ? sk_x_q : fin_x_q;
  assign sample_y_o  = sk_vld_q ? sk_y_q : fin_y_q;
  assign bad_face_o  = sk_vld_q ? sk_bad_q : fin_bad_q;

  // checks
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_face_o |-> sample_x_o == '0 && sample_y_o == '0)
    else $error("bad face word carries nonzero coordinates");

  a_skid_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(sk_vld_q) |-> $past(fin_vld_q && !out_ready_i))
    else $error("skid filled without a stalled result");

  a_div_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    du_vld |-> dv_vld && du_face == dv_face)
    else $error("pixel dividers out of step");

  // vectoring only grows x, so the latitude magnitude never goes negative
  a_lat_mag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c2_vld |-> c2_x >= 0)
    else $error("latitude pass magnitude went negative");

endmodule

`default_nettype wire
